@@ rtl/bspb_pkg.sv @@
// Brush stamp pixel blend: shared widths, register indexes, brush kinds,
// pipeline word types and the constant-divide helpers.
// No dependencies.
`default_nettype none

package bspb_pkg;

  localparam int OFS_W      = 8;
  localparam int PIX_W      = 32;
  localparam int KIND_W     = 2;
  localparam int SIZE_W     = 6;
  localparam int PCT_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int MAX_BRUSH_SIZE_DEF = 50;

  localparam int D2_W   = 16;
  localparam int ROOT_W = 24;
  localparam int REM_W  = 28;
  localparam int SQ_N   = ROOT_W;
  localparam int RA_W   = 7;
  localparam int NUM_W  = 23;
  localparam int QUO_W  = 17;

  typedef enum logic [KIND_W-1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_ROUND  = 2'd1,
    KIND_AIR    = 2'd2,
    KIND_CHISEL = 2'd3
  } kind_t;

  localparam logic [CFG_IDX_W-1:0] REG_KIND     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HARDNESS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OPACITY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR    = 3'd4;

  localparam logic [SIZE_W-1:0] SIZE_RST     = 6'd6;
  localparam logic [PCT_W-1:0]  HARD_RST     = 7'd80;
  localparam logic [PCT_W-1:0]  OPAC_RST     = 7'd100;
  localparam logic [PCT_W-1:0]  PCT_MAX      = 7'd100;
  localparam logic [PIX_W-1:0]  COLOR_RST    = 32'hFF00_0000;

  localparam logic [23:0] DIV100_MUL = 24'd10737419;
  localparam logic [16:0] DIV255_MUL = 17'd32897;
  localparam logic [16:0] HF_BASE    = 17'd19661;
  localparam logic [15:0] HF_SCALE   = 16'd45875;
  localparam logic [14:0] BQ_SCALE   = 15'd22938;

  typedef struct packed {
    logic [PIX_W-1:0]  dst;
    logic              hit;
    logic [D2_W-1:0]   d2;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  typedef struct packed {
    logic [PIX_W-1:0] dst;
    logic             hit;
    logic [NUM_W-1:0] num;
    logic [QUO_W-1:0] quo;
  } dv_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             cov;
  } res_t;

  // floor(y / 100) for y below 2**23
  function automatic logic [QUO_W-1:0] div100(input logic [NUM_W-1:0] y);
    logic [46:0] p;
    p = 47'(y) * 47'(DIV100_MUL);
    return p[46:30];
  endfunction

  // floor(y / 255) for y up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] y);
    logic [32:0] p;
    p = 33'(y) * 33'(DIV255_MUL);
    return p[30:23];
  endfunction

  function automatic sq_t sq_step(input sq_t a);
    sq_t b;
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    b     = a;
    cur   = {a.rem[REM_W-3:0], a.d2[D2_W-1:D2_W-2]};
    trial = REM_W'({a.root, 2'b01});
    b.d2  = {a.d2[D2_W-3:0], 2'b00};
    if (cur >= trial) begin
      b.rem  = cur - trial;
      b.root = {a.root[ROOT_W-2:0], 1'b1};
    end else begin
      b.rem  = cur;
      b.root = {a.root[ROOT_W-2:0], 1'b0};
    end
    return b;
  endfunction

  function automatic dv_t dv_step(input dv_t a, input logic [RA_W-1:0] r,
                                  input logic [4:0] sh);
    dv_t b;
    logic [NUM_W-1:0] sub;
    b   = a;
    sub = NUM_W'(r) << sh;
    if (a.num >= sub) begin
      b.num = a.num - sub;
      b.quo = {a.quo[QUO_W-2:0], 1'b1};
    end else begin
      b.quo = {a.quo[QUO_W-2:0], 1'b0};
    end
    return b;
  endfunction

endpackage

`default_nettype wire

@@ rtl/bspb_if.sv @@
// Brush stamp pixel blend: input and result channel interfaces.
// Depends on bspb_pkg.
`default_nettype none

interface bspb_in_if;
  import bspb_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OFS_W-1:0] offset_x;
  logic signed [OFS_W-1:0] offset_y;
  logic [PIX_W-1:0]        dest_pixel;
  modport source (output valid, offset_x, offset_y, dest_pixel, input ready);
  modport sink   (input valid, offset_x, offset_y, dest_pixel, output ready);
endinterface

interface bspb_out_if;
  import bspb_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] new_pixel;
  logic             covered;
  modport source (output valid, new_pixel, covered, input ready);
  modport sink   (input valid, new_pixel, covered, output ready);
endinterface

`default_nettype wire

@@ rtl/brush_stamp_pixel_blend.sv @@
// Brush stamp pixel blend top level: config registers, shape tests, sqrt and
// divide pipelines, airbrush alpha and source-over blend. Depends on bspb_pkg, bspb_if.
// Throughput: one word per cycle while the output skid is empty (in_ch.ready high);
// the 24-stage root and 17-stage divide set the depth.
// Reset: config registers return to their defaults, all stage valids clear.
`default_nettype none

module brush_stamp_pixel_blend #(
  parameter int MAX_BRUSH_SIZE = bspb_pkg::MAX_BRUSH_SIZE_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [bspb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bspb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  bspb_in_if.sink                             in_ch,
  bspb_out_if.source                          out_ch
);
  import bspb_pkg::*;

  localparam logic [SIZE_W-1:0] MAX_S = SIZE_W'(MAX_BRUSH_SIZE);

  kind_t             kind_r;
  logic [SIZE_W-1:0] size_r;
  logic [PCT_W-1:0]  hard_r;
  logic [PCT_W-1:0]  opac_r;
  logic [PIX_W-1:0]  color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= KIND_ROUND;
      size_r  <= SIZE_RST;
      hard_r  <= HARD_RST;
      opac_r  <= OPAC_RST;
      color_r <= COLOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KIND:     kind_r  <= kind_t'(cfg_wdata[KIND_W-1:0]);
        REG_SIZE:     size_r  <= cfg_wdata[SIZE_W-1:0];
        REG_HARDNESS: hard_r  <= cfg_wdata[PCT_W-1:0];
        REG_OPACITY:  opac_r  <= cfg_wdata[PCT_W-1:0];
        REG_COLOR:    color_r <= cfg_wdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  logic [SIZE_W-1:0] s_c;
  logic [PCT_W-1:0]  hard_c;
  logic [PCT_W-1:0]  opac_c;
  logic [RA_W-1:0]   ra_c;

  always_comb begin
    if (size_r == '0) begin
      s_c = SIZE_W'(1);
    end else if (size_r > MAX_S) begin
      s_c = MAX_S;
    end else begin
      s_c = size_r;
    end
    hard_c = (hard_r > PCT_MAX) ? PCT_MAX : hard_r;
    opac_c = (opac_r > PCT_MAX) ? PCT_MAX : opac_r;
    ra_c   = RA_W'((9'(s_c) * 9'd3) >> 1) + RA_W'(2);
  end

  // derived brush constants, settled long before any word needs them
  logic [11:0]      s2_r;
  logic [RA_W-1:0]  ra_r;
  logic [13:0]      ra2_r;
  logic [14:0]      yop8_r;
  logic [NUM_W-1:0] yopq_r;
  logic [NUM_W-1:0] yhf_r;
  logic [7:0]       op8_r;
  logic [QUO_W-1:0] opq_r;
  logic [QUO_W-1:0] hf_r;
  logic [QUO_W-1:0] ohf_r;
  logic [14:0]      bq_r;
  logic [33:0]      ohf_p;
  logic [31:0]      bq_p;

  assign ohf_p = 34'(opq_r) * 34'(hf_r);
  assign bq_p  = 32'(ohf_r) * 32'(BQ_SCALE);

  always_ff @(posedge clk) begin
    s2_r   <= 12'(s_c) * 12'(s_c);
    ra_r   <= ra_c;
    ra2_r  <= 14'(ra_c) * 14'(ra_c);
    yop8_r <= 15'(opac_c) * 15'd255;
    yopq_r <= NUM_W'({opac_c, 16'h0000});
    yhf_r  <= NUM_W'(hard_c) * NUM_W'(HF_SCALE);
    op8_r  <= 8'(div100(NUM_W'(yop8_r)));
    opq_r  <= div100(yopq_r);
    hf_r   <= div100(yhf_r) + HF_BASE;
    ohf_r  <= ohf_p[32:16];
    bq_r   <= bq_p[30:16];
  end

  logic en;
  logic skid_v_r;
  assign en          = !skid_v_r;
  assign in_ch.ready = en;

  // P0: capture word
  logic                    p0_v_r;
  logic signed [OFS_W-1:0] p0_dx_r;
  logic signed [OFS_W-1:0] p0_dy_r;
  logic [PIX_W-1:0]        p0_dst_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_v_r <= 1'b0;
    end else if (en) begin
      p0_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_dx_r  <= in_ch.offset_x;
      p0_dy_r  <= in_ch.offset_y;
      p0_dst_r <= in_ch.dest_pixel;
    end
  end

  // P1: distances and square / band tests
  logic signed [9:0] dx, dy, sxy, dyx, half, hi;
  logic [9:0]        ax, ay, asum, adif, rc, t2;
  logic [4:0]        t3;
  logic [11:0]       s43;
  logic [D2_W-1:0]   d2_nxt;
  logic              pix_nxt, chi_nxt;

  always_comb begin
    dx     = 10'(p0_dx_r);
    dy     = 10'(p0_dy_r);
    sxy    = dx + dy;
    dyx    = dy - dx;
    ax     = (dx < 0) ? 10'(-dx) : 10'(dx);
    ay     = (dy < 0) ? 10'(-dy) : 10'(dy);
    asum   = (sxy < 0) ? 10'(-sxy) : 10'(sxy);
    adif   = (dyx < 0) ? 10'(-dyx) : 10'(dyx);
    d2_nxt = D2_W'(ax) * D2_W'(ax) + D2_W'(ay) * D2_W'(ay);
    half   = signed'(10'(s_c[SIZE_W-1:1]));
    hi     = signed'(10'(s_c)) - half;
    pix_nxt = (dx >= -half) && (dx < hi) && (dy >= -half) && (dy < hi);
    s43    = 12'(s_c) * 12'd43;
    t3     = 5'(s43[11:7]) + 5'd1;
    t2     = 10'({t3, 1'b0});
    rc     = 10'({s_c, 1'b0}) + 10'd2;
    chi_nxt = (ax <= rc) && (ay <= rc) && (asum <= rc) && (adif <= t2);
  end

  logic             p1_v_r;
  logic [PIX_W-1:0] p1_dst_r;
  logic [D2_W-1:0]  p1_d2_r;
  logic             p1_pix_r, p1_chi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (en) begin
      p1_v_r <= p0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_dst_r <= p0_dst_r;
      p1_d2_r  <= d2_nxt;
      p1_pix_r <= pix_nxt;
      p1_chi_r <= chi_nxt;
    end
  end

  // P2: pick the coverage test of the brush kind
  logic hit_nxt;
  always_comb begin
    unique case (kind_r)
      KIND_PIXEL:  hit_nxt = p1_pix_r;
      KIND_ROUND:  hit_nxt = (D2_W'(s2_r) >= p1_d2_r);
      KIND_AIR:    hit_nxt = (D2_W'(ra2_r) >= p1_d2_r);
      KIND_CHISEL: hit_nxt = p1_chi_r;
      default:     hit_nxt = 1'b0;
    endcase
  end

  logic p2_v_r;
  sq_t  p2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else if (en) begin
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_r.dst  <= p1_dst_r;
      p2_r.hit  <= hit_nxt;
      p2_r.d2   <= p1_d2_r;
      p2_r.rem  <= '0;
      p2_r.root <= '0;
    end
  end

  // root of d2 * 2**32, one result bit per stage
  logic sq_v_r [SQ_N];
  sq_t  sq_r   [SQ_N];
  sq_t  sq_nxt [SQ_N];

  always_comb begin
    sq_nxt[0] = sq_step(p2_r);
    for (int i = 1; i < SQ_N; i++) begin
      sq_nxt[i] = sq_step(sq_r[i-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SQ_N; i++) begin
        sq_v_r[i] <= 1'b0;
      end
    end else if (en) begin
      sq_v_r[0] <= p2_v_r;
      for (int i = 1; i < SQ_N; i++) begin
        sq_v_r[i] <= sq_v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < SQ_N; i++) begin
        sq_r[i] <= sq_nxt[i];
      end
    end
  end

  // falloff numerator r * 2**16 - dq
  logic [ROOT_W-1:0] full_w;
  logic [ROOT_W-1:0] dq;
  logic [ROOT_W-1:0] numw;
  logic              dv0_v_r;
  dv_t               dv0_r;

  assign full_w = ROOT_W'({ra_r, 16'h0000});
  assign dq     = sq_r[SQ_N-1].root;
  assign numw   = (full_w > dq) ? (full_w - dq) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv0_v_r <= 1'b0;
    end else if (en) begin
      dv0_v_r <= sq_v_r[SQ_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv0_r.dst <= sq_r[SQ_N-1].dst;
      dv0_r.hit <= sq_r[SQ_N-1].hit;
      dv0_r.num <= numw[NUM_W-1:0];
      dv0_r.quo <= '0;
    end
  end

  // divide by r, one quotient bit per stage
  logic dv_v_r [QUO_W];
  dv_t  dv_r   [QUO_W];
  dv_t  dv_nxt [QUO_W];

  always_comb begin
    dv_nxt[0] = dv_step(dv0_r, ra_r, 5'(QUO_W - 1));
    for (int i = 1; i < QUO_W; i++) begin
      dv_nxt[i] = dv_step(dv_r[i-1], ra_r, 5'(QUO_W - 1 - i));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QUO_W; i++) begin
        dv_v_r[i] <= 1'b0;
      end
    end else if (en) begin
      dv_v_r[0] <= dv0_v_r;
      for (int i = 1; i < QUO_W; i++) begin
        dv_v_r[i] <= dv_v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < QUO_W; i++) begin
        dv_r[i] <= dv_nxt[i];
      end
    end
  end

  // F1..F3: airbrush alpha, or the opacity alpha for the other kinds
  logic [33:0]      uu;
  logic             f1_v_r, f2_v_r, f3_v_r;
  logic [PIX_W-1:0] f1_dst_r, f2_dst_r, f3_dst_r;
  logic             f1_hit_r, f2_hit_r, f3_hit_r;
  logic [QUO_W-1:0] f1_f_r;
  logic [31:0]      f2_fb_r;
  logic [7:0]       f3_alpha_r;
  logic [39:0]      a255;
  logic [7:0]       a_air;
  logic             hit_f_nxt;
  logic [7:0]       alpha_nxt;

  assign uu = 34'(dv_r[QUO_W-1].quo) * 34'(dv_r[QUO_W-1].quo);
  assign a255 = {f2_fb_r, 8'h00} - 40'(f2_fb_r);
  assign a_air = a255[39:32];

  always_comb begin
    if (kind_r == KIND_AIR) begin
      hit_f_nxt = f2_hit_r && (a_air != 8'h00);
      alpha_nxt = a_air;
    end else begin
      hit_f_nxt = f2_hit_r;
      alpha_nxt = op8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      f3_v_r <= 1'b0;
    end else if (en) begin
      f1_v_r <= dv_v_r[QUO_W-1];
      f2_v_r <= f1_v_r;
      f3_v_r <= f2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_dst_r   <= dv_r[QUO_W-1].dst;
      f1_hit_r   <= dv_r[QUO_W-1].hit;
      f1_f_r     <= uu[32:16];
      f2_dst_r   <= f1_dst_r;
      f2_hit_r   <= f1_hit_r;
      f2_fb_r    <= 32'(f1_f_r) * 32'(bq_r);
      f3_dst_r   <= f2_dst_r;
      f3_hit_r   <= hit_f_nxt;
      f3_alpha_r <= alpha_nxt;
    end
  end

  // M1..M3: source-over blend
  logic             m1_v_r, m2_v_r, m3_v_r;
  logic [PIX_W-1:0] m1_dst_r, m2_dst_r, m3_dst_r;
  logic             m1_hit_r, m2_hit_r, m3_hit_r;
  logic [15:0]      m1_prod_r;
  logic [7:0]       m2_sa_r, m3_sa_r;
  logic [7:0]       inv;
  logic [15:0]      m3_sum_r [4];

  assign inv = 8'd255 - m2_sa_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
      m3_v_r <= 1'b0;
    end else if (en) begin
      m1_v_r <= f3_v_r;
      m2_v_r <= m1_v_r;
      m3_v_r <= m2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_dst_r  <= f3_dst_r;
      m1_hit_r  <= f3_hit_r;
      m1_prod_r <= 16'(color_r[31:24]) * 16'(f3_alpha_r);
      m2_dst_r  <= m1_dst_r;
      m2_hit_r  <= m1_hit_r;
      m2_sa_r   <= div255(m1_prod_r);
      m3_dst_r  <= m2_dst_r;
      m3_hit_r  <= m2_hit_r;
      m3_sa_r   <= m2_sa_r;
      for (int k = 0; k < 3; k++) begin
        m3_sum_r[k] <= 16'(color_r[8*k +: 8]) * 16'(m2_sa_r)
                     + 16'(m2_dst_r[8*k +: 8]) * 16'(inv);
      end
      m3_sum_r[3] <= 16'(m2_dst_r[31:24]) * 16'(inv);
    end
  end

  res_t tail;
  always_comb begin
    tail.cov = m3_hit_r;
    if (!m3_hit_r) begin
      tail.pix = m3_dst_r;
    end else if (kind_r == KIND_PIXEL) begin
      tail.pix = color_r;
    end else if (m3_sa_r == 8'h00) begin
      tail.pix = m3_dst_r;
    end else if (m3_sa_r == 8'hFF) begin
      tail.pix = {8'hFF, color_r[23:0]};
    end else begin
      tail.pix = {m3_sa_r + div255(m3_sum_r[3]), div255(m3_sum_r[2]),
                  div255(m3_sum_r[1]), div255(m3_sum_r[0])};
    end
  end

  // output word and skid
  logic out_v_r;
  res_t out_r;
  res_t skid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (en) begin
      if (!out_v_r || out_ch.ready) begin
        out_v_r <= m3_v_r;
      end else if (m3_v_r) begin
        skid_v_r <= 1'b1;
      end
    end else if (out_ch.ready) begin
      skid_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!out_v_r || out_ch.ready) begin
        out_r <= tail;
      end else begin
        skid_r <= tail;
      end
    end else if (out_ch.ready) begin
      out_r <= skid_r;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.new_pixel = out_r.pix;
  assign out_ch.covered   = out_r.cov;

endmodule

`default_nettype wire

@@ test/tb.sv @@
// Testbench for brush_stamp_pixel_blend: stamps random and edge-case pixels
// through every brush kind and a range of register settings and checks each result word.
// Depends on rtl/bspb_pkg.sv, rtl/bspb_if.sv and rtl/brush_stamp_pixel_blend.sv.
`timescale 1ns / 100ps

module tb;
  import bspb_pkg::*;

  typedef struct {
    logic signed [OFS_W-1:0] ox;
    logic signed [OFS_W-1:0] oy;
    logic [PIX_W-1:0]        dst;
  } stamp_req_t;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  bspb_in_if  in_ch ();
  bspb_out_if out_ch ();

  brush_stamp_pixel_blend i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #1 clk = ~clk;

  // shadow registers
  logic [KIND_W-1:0] kind_r = KIND_ROUND;
  logic [SIZE_W-1:0] size_r = SIZE_RST;
  logic [PCT_W-1:0]  hard_r = HARD_RST;
  logic [PCT_W-1:0]  opac_r = OPAC_RST;
  logic [PIX_W-1:0]  color_r = COLOR_RST;

  stamp_req_t pending_px[$];
  res_t       expected_px[$];
  int fails = 0;
  int n_words = 0;
  int n_covered = 0;
  int cycles = 0;
  bit want_hold = 0;
  bit hold_done = 0;
  bit in_fire = 0;

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] src_over(input logic [31:0] dst, input logic [31:0] src,
                                           input int unsigned alpha);
    int unsigned sa, inv, r, g, b, a;
    sa = src[31:24] * alpha / 255;
    if (sa == 0) return dst;
    if (sa >= 255) return {8'hFF, src[23:0]};
    inv = 255 - sa;
    r = (src[7:0] * sa + dst[7:0] * inv) / 255;
    g = (src[15:8] * sa + dst[15:8] * inv) / 255;
    b = (src[23:16] * sa + dst[23:16] * inv) / 255;
    a = sa + dst[31:24] * inv / 255;
    return {a[7:0], b[7:0], g[7:0], r[7:0]};
  endfunction

  function automatic int iabs(input int v);
    return v < 0 ? -v : v;
  endfunction

  function automatic res_t stamp_pixel(input stamp_req_t q);
    res_t o;
    int dx, dy, s, half, rc, t;
    int unsigned hard, opac, op8, d2, r;
    longint unsigned dq, full, u, f, opq, hf, bq, a;
    dx = q.ox;
    dy = q.oy;
    s = size_r;
    if (s < 1) s = 1;
    if (s > MAX_BRUSH_SIZE_DEF) s = MAX_BRUSH_SIZE_DEF;
    hard = hard_r > PCT_MAX ? PCT_MAX : hard_r;
    opac = opac_r > PCT_MAX ? PCT_MAX : opac_r;
    op8 = opac * 255 / 100;
    d2 = dx * dx + dy * dy;
    o.pix = q.dst;
    o.cov = 1'b0;
    case (kind_t'(kind_r))
      KIND_PIXEL: begin
        half = s / 2;
        if (dx >= -half && dx < s - half && dy >= -half && dy < s - half) begin
          o.cov = 1'b1;
          o.pix = color_r;
        end
      end
      KIND_ROUND: begin
        if (d2 <= s * s) begin
          o.cov = 1'b1;
          o.pix = src_over(q.dst, color_r, op8);
        end
      end
      KIND_AIR: begin
        r = (s * 3) / 2 + 2;
        if (d2 <= r * r) begin
          dq = int_sqrt(longint'(d2) << 32);
          full = longint'(r) << 16;
          u = (full > dq ? full - dq : 0) / r;
          f = (u * u) >> 16;
          opq = opac * 64'd65536 / 100;
          hf = hard * 64'd45875 / 100 + 19661;
          bq = (((opq * hf) >> 16) * 22938) >> 16;
          a = (255 * f * bq) >> 32;
          if (a > 255) a = 255;
          if (a > 0) begin
            o.cov = 1'b1;
            o.pix = src_over(q.dst, color_r, a);
          end
        end
      end
      default: begin
        rc = s * 2 + 2;
        t = s / 3 + 1;
        if (iabs(dx) <= rc && iabs(dy) <= rc && iabs(dx + dy) <= rc &&
            iabs(dy - dx) <= t * 2) begin
          o.cov = 1'b1;
          o.pix = src_over(q.dst, color_r, op8);
        end
      end
    endcase
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH word %0d %s: got %h want %h", n_words, what, got, want);
    fails++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_KIND:     kind_r = val[KIND_W-1:0];
      REG_SIZE:     size_r = val[SIZE_W-1:0];
      REG_HARDNESS: hard_r = val[PCT_W-1:0];
      REG_OPACITY:  opac_r = val[PCT_W-1:0];
      default:      color_r = val;
    endcase
  endtask

  task automatic push_px(input int ox, input int oy, input logic [31:0] dst);
    stamp_req_t q;
    q.ox = ox[7:0];
    q.oy = oy[7:0];
    q.dst = dst;
    pending_px.push_back(q);
  endtask

  task automatic drain;
    wait (pending_px.size() == 0 && !in_ch.valid && expected_px.size() == 0);
    repeat (60) @(negedge clk);
  endtask

  // driver: hold the word until accepted, then advance
  int burst_left = 0;
  int gap_left = 0;
  initial begin
    in_ch.valid = 1'b0;
    in_ch.offset_x = '0;
    in_ch.offset_y = '0;
    in_ch.dest_pixel = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) in_fire <= rst_n && in_ch.valid && in_ch.ready;

  always @(negedge clk) begin
    if (in_fire) begin
      expected_px.push_back(stamp_pixel(pending_px.pop_front()));
    end
    if (!rst_n) begin
      in_ch.valid = 1'b0;
    end else if (in_ch.valid && !in_fire) begin
      in_ch.valid = 1'b1;
    end else if (gap_left > 0) begin
      gap_left--;
      in_ch.valid = 1'b0;
    end else if (pending_px.size() > 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      if (burst_left == 0) begin
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
      end
      in_ch.offset_x = pending_px[0].ox;
      in_ch.offset_y = pending_px[0].oy;
      in_ch.dest_pixel = pending_px[0].dst;
      in_ch.valid = 1'b1;
    end else begin
      in_ch.valid = 1'b0;
    end
  end

  // receiver stall pattern with one long hold-off
  int hold_left = 0;
  int stall_mode = 0;
  always @(negedge clk) begin
    if (want_hold && !hold_done) begin
      hold_done = 1;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready = 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0:       out_ch.ready = 1'b1;
        1:       out_ch.ready = ($urandom_range(0, 3) != 0);
        default: out_ch.ready = ($urandom_range(0, 1) != 0);
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin
    res_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_px.size() == 0) begin
        $display("MISMATCH unexpected word %h cov %b", out_ch.new_pixel, out_ch.covered);
        fails++;
      end else begin
        w = expected_px.pop_front();
        if (out_ch.new_pixel !== w.pix) report_mismatch("new_pixel", out_ch.new_pixel, w.pix);
        if (out_ch.covered !== w.cov) report_mismatch("covered", out_ch.covered, w.cov);
        if (w.cov) n_covered++;
      end
      n_words++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int near_ofs(input int reach);
    if ($urandom_range(0, 4) == 0) return $signed(8'($urandom()));
    return $urandom_range(0, 2 * reach) - reach;
  endfunction

  function automatic logic [31:0] pick_color();
    logic [31:0] c;
    c = $urandom();
    case ($urandom_range(0, 3))
      0:       c[31:24] = 8'h00;
      1:       c[31:24] = 8'hFF;
      default: ;
    endcase
    return c;
  endfunction

  initial begin
    int reach;
    logic [31:0] sz;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // reset settings: round brush size 6
    push_px(0, 0, 32'h0000_0000);
    push_px(6, 0, 32'hFFFF_FFFF);
    push_px(7, 0, 32'h1234_5678);
    push_px(-128, -128, 32'hFFFF_FFFF);
    push_px(127, 127, 32'h0);
    push_px(-127, 0, 32'hA5A5_A5A5);
    push_px(-4, 4, 32'h5A5A_5A5A);
    drain();
    write_reg(REG_COLOR, 32'h00FF_FFFF);
    push_px(0, 0, 32'h8040_2010);
    drain();
    write_reg(REG_KIND, KIND_PIXEL);
    write_reg(REG_SIZE, 0);
    push_px(0, 0, 32'h0);
    push_px(1, 0, 32'h0);
    drain();
    write_reg(REG_KIND, KIND_AIR);
    write_reg(REG_SIZE, 63);
    write_reg(REG_HARDNESS, 127);
    write_reg(REG_OPACITY, 127);
    write_reg(REG_COLOR, 32'hFF33_66CC);
    push_px(0, 0, 32'h0);
    push_px(76, 0, 32'h0);
    push_px(-77, 0, 32'h0);
    push_px(40, -40, 32'hFFFF_FFFF);
    drain();
    write_reg(REG_KIND, KIND_CHISEL);
    write_reg(REG_OPACITY, 0);
    write_reg(REG_HARDNESS, 0);
    push_px(10, 10, 32'h0);
    push_px(-102, -102, 32'h0);
    drain();

    for (int p = 0; p < 24; p++) begin
      write_reg(REG_KIND, p % 4);
      case (p % 6)
        0:       sz = 1;
        1:       sz = 50;
        2:       sz = $urandom_range(0, 63);
        default: sz = $urandom_range(1, 12);
      endcase
      write_reg(REG_SIZE, sz);
      write_reg(REG_HARDNESS, (p % 5 == 0) ? 0 : (p % 5 == 1) ? 100 : $urandom_range(0, 127));
      write_reg(REG_OPACITY, (p % 7 == 0) ? 1 : (p % 7 == 1) ? 100 : $urandom_range(0, 127));
      write_reg(REG_COLOR, pick_color());
      reach = 2 * ((size_r == 0) ? 1 : (size_r > 50 ? 50 : size_r)) + 6;
      if (reach > 127) reach = 127;
      if (p == 5) want_hold = 1;
      for (int k = 0; k < ((p == 5) ? 120 : 40); k++) begin
        push_px(near_ofs(reach), near_ofs(reach), $urandom());
      end
      drain();
    end

    $display("Checked %0d result words, %0d covered, over 24 register settings", n_words,
             n_covered);
    $display("All four brush kinds, clamped sizes and percentages, and a long output stall");
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
